[rtl/core/sah_pkg.sv]
// Shared types, constants and helpers for the angle-halving sine/cosine block.
// Used by the controller, the datapath, the multiplier and the divider.
// No dependencies.
`default_nettype none

package sah_pkg;

  // Field and format widths
  localparam int ANGLE_W    = 32;
  localparam int OUT_W      = 30;
  localparam int THR_W      = 32;
  localparam int INNER_W    = 64;
  localparam int ANGLE_FRAC = 28;
  localparam int THR_FRAC   = 40;

  // Defaults for the top-level parameters
  localparam int MAX_HALVINGS_DEF = 32;
  localparam int INNER_FRAC_DEF   = 60;

  // Threshold register reset value (about 1e-8 rad in 2^-40 units)
  localparam logic [THR_W-1:0] THR_RESET = 32'd10995;

  // Multiplier splits operands into halves
  localparam int HALF_W = INNER_W / 2;

  // Multiply operations: operands and destination are implied
  typedef enum logic [2:0] {
    MOP_XX,    // x * x    -> p0
    MOP_X2X,   // p0 * x   -> p1
    MOP_X2X2,  // p0 * p0  -> p2
    MOP_SC,    // s * c    -> p0
    MOP_CC,    // c * c    -> p1
    MOP_SS     // s * s    -> p2
  } mul_op_t;

  // Divide operations
  typedef enum logic {
    DOP_6,     // p1 / 6  -> p1
    DOP_24     // p2 / 24 -> p2
  } div_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    halve;
    logic    clamp_x;
    logic    mul_start;
    mul_op_t mul_op;
    logic    div_start;
    div_op_t div_op;
    logic    seed;
    logic    update;
    logic    finish;
  } sah_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic x_ge_thr;
    logic mul_done;
    logic div_done;
  } sah_status_t;

  // Clamp an inner value to [-one, +one]
  function automatic logic signed [INNER_W-1:0] clamp_one(
    input logic signed [INNER_W-1:0] v,
    input logic signed [INNER_W-1:0] one
  );
    logic signed [INNER_W-1:0] r;
    begin
      r = v;
      if (v > one) begin
        r = one;
      end else if (v < -one) begin
        r = -one;
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/sah_mul.sv]
// Sequential 64x64 unsigned multiplier: one 32x32 partial product per cycle,
// result shifted right by the fraction width and saturated to 2^63-1.
// Depends on sah_pkg.
`default_nettype none

module sah_mul import sah_pkg::*; #(
  parameter int FRAC_BITS = INNER_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [INNER_W-1:0] a,
  input  logic [INNER_W-1:0] b,
  output logic               done,
  output logic [INNER_W-1:0] prod
);

  localparam int ACC_W = 2 * INNER_W;

  logic                running;
  logic [1:0]          cnt;
  logic [HALF_W-1:0]   a_part;
  logic [HALF_W-1:0]   b_part;
  logic [INNER_W-1:0]  pp;
  logic [1:0]          pp_sh;
  logic                pp_vld;
  logic                pp_last;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    shifted;

  // Partial product select: a0b0, a0b1, a1b0, a1b1
  assign a_part = cnt[1] ? a[INNER_W-1:HALF_W] : a[HALF_W-1:0];
  assign b_part = cnt[0] ? b[INNER_W-1:HALF_W] : b[HALF_W-1:0];

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      pp_vld  <= 1'b0;
      pp_last <= 1'b0;
      done    <= 1'b0;
    end else begin
      pp_vld  <= running;
      pp_last <= running && (cnt == 2'd3);
      done    <= pp_vld && pp_last;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Partial product register, then accumulate
  always_ff @(posedge clk) begin
    pp    <= a_part * b_part;
    pp_sh <= 2'({1'b0, cnt[1]} + {1'b0, cnt[0]});
    if (start) begin
      acc <= '0;
    end else if (pp_vld) begin
      acc <= acc + (ACC_W'(pp) << {pp_sh, 5'b0});
    end
  end

  // Scale and saturate
  assign shifted = acc >> FRAC_BITS;
  assign prod = (|shifted[ACC_W-1:INNER_W-1]) ? {1'b0, {(INNER_W-1){1'b1}}}
                                               : shifted[INNER_W-1:0];

endmodule

`default_nettype wire

[rtl/core/sah_div.sv]
// Unsigned divider by 6 or 24 for the series seed: a right shift by one or
// three, then a divide by 3 as a multiply by 0x5555555555555556 built from
// shift-and-add folds, one 128-bit add per cycle. Depends on sah_pkg.
`default_nettype none

module sah_div import sah_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [INNER_W-1:0] dividend,
  input  div_op_t            op,
  output logic               done,
  output logic [INNER_W-1:0] quotient
);

  localparam int ACC_W  = 2 * INNER_W;
  localparam int FOLDS  = 5;
  localparam int STEP_W = 3;

  logic                running;
  logic [STEP_W-1:0]   step;
  logic [INNER_W-1:0]  n;
  logic [INNER_W-1:0]  n_shifted;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    acc_next;

  // Power-of-two part of the divisor; dividends stay below 2^63
  assign n_shifted = (op == DOP_24) ? (dividend >> 3) : (dividend >> 1);

  // n * 0x55..55 by folding 5 -> 0x55 -> 0x5555 -> ..., then plus n
  always_comb begin
    case (step)
      3'd0:    acc_next = acc + (acc << 2);
      3'd1:    acc_next = acc + (acc << 4);
      3'd2:    acc_next = acc + (acc << 8);
      3'd3:    acc_next = acc + (acc << 16);
      3'd4:    acc_next = acc + (acc << 32);
      default: acc_next = acc + {{INNER_W{1'b0}}, n};
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(FOLDS)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      n   <= n_shifted;
      acc <= {{INNER_W{1'b0}}, n_shifted};
    end else if (running) begin
      acc <= acc_next;
    end
  end

  // Upper half of n * (2^64 + 2) / 3 is floor(n / 3)
  assign quotient = acc[ACC_W-1:INNER_W];

endmodule

`default_nettype wire

[rtl/core/sah_datapath.sv]
// Datapath: threshold register, angle halving, series seed, double-angle
// update and output conversion. Holds the shared multiplier and divider.
// Depends on sah_pkg, sah_mul, sah_div.
`default_nettype none

module sah_datapath import sah_pkg::*; #(
  parameter int FRAC_BITS = INNER_FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [THR_W-1:0]         cfg_wr_data,
  input  logic signed [ANGLE_W-1:0] angle_in,
  input  sah_cmd_t                 cmd,
  output sah_status_t              status,
  output logic signed [OUT_W-1:0]  sine_out,
  output logic signed [OUT_W-1:0]  cosine_out
);

  localparam logic [INNER_W-1:0]        ONE   = INNER_W'(1) << FRAC_BITS;
  localparam logic signed [INNER_W-1:0] ONE_S = ONE;

  logic [THR_W-1:0]          thr;
  logic [INNER_W-1:0]        thr_scaled;
  logic                      neg;
  logic [INNER_W-1:0]        x;
  logic [ANGLE_W-1:0]        amag;
  logic signed [INNER_W-1:0] s, c, p0, p1, p2;
  logic [INNER_W-1:0]        mul_a, mul_b, mul_prod;
  logic                      mul_neg, mul_done;
  logic signed [INNER_W-1:0] mul_res;
  logic [INNER_W-1:0]        div_in, div_quot;
  logic                      div_done;
  logic signed [INNER_W-1:0] s_signed;

  function automatic logic [INNER_W-1:0] mag(input logic signed [INNER_W-1:0] v);
    return v[INNER_W-1] ? INNER_W'(-v) : INNER_W'(v);
  endfunction

  // Inner value to Q1.28, truncating toward zero
  function automatic logic [OUT_W-1:0] to_q28(input logic signed [INNER_W-1:0] v);
    logic [INNER_W-1:0] m;
    begin
      m = mag(v) >> (FRAC_BITS - ANGLE_FRAC);
      return v[INNER_W-1] ? OUT_W'(-m) : m[OUT_W-1:0];
    end
  endfunction

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  assign thr_scaled = {{(INNER_W-THR_W){1'b0}}, thr} << (FRAC_BITS - THR_FRAC);
  assign amag = angle_in[ANGLE_W-1] ? ANGLE_W'(-angle_in) : ANGLE_W'(angle_in);

  // Multiplier operand select (magnitudes) and product sign
  always_comb begin
    mul_a   = x;
    mul_b   = x;
    mul_neg = 1'b0;
    case (cmd.mul_op)
      MOP_XX: begin
        mul_a = x;
        mul_b = x;
      end
      MOP_X2X: begin
        mul_a = INNER_W'(p0);
        mul_b = x;
      end
      MOP_X2X2: begin
        mul_a = INNER_W'(p0);
        mul_b = INNER_W'(p0);
      end
      MOP_SC: begin
        mul_a   = mag(s);
        mul_b   = mag(c);
        mul_neg = s[INNER_W-1] ^ c[INNER_W-1];
      end
      MOP_CC: begin
        mul_a = mag(c);
        mul_b = mag(c);
      end
      MOP_SS: begin
        mul_a = mag(s);
        mul_b = mag(s);
      end
      default: begin
        mul_a = x;
        mul_b = x;
      end
    endcase
  end

  sah_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign mul_res = mul_neg ? -$signed(mul_prod) : $signed(mul_prod);

  // Divider operand select
  assign div_in = (cmd.div_op == DOP_6) ? INNER_W'(p1) : INNER_W'(p2);

  sah_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_in),
    .op       (cmd.div_op),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Status back to the controller
  always_comb begin
    status.x_ge_thr = (x >= thr_scaled);
    status.mul_done = mul_done;
    status.div_done = div_done;
  end

  assign s_signed = neg ? -s : s;

  // Working registers
  always_ff @(posedge clk) begin
    // angle capture, halving, clamp to 1.0
    if (cmd.load) begin
      neg <= angle_in[ANGLE_W-1];
      x   <= {{(INNER_W-ANGLE_W){1'b0}}, amag} << (FRAC_BITS - ANGLE_FRAC);
    end else if (cmd.halve) begin
      x <= x >> 1;
    end else if (cmd.clamp_x && (x > ONE)) begin
      x <= ONE;
    end

    // product write-back
    if (mul_done) begin
      case (cmd.mul_op)
        MOP_XX, MOP_SC:   p0 <= mul_res;
        MOP_X2X, MOP_CC:  p1 <= mul_res;
        MOP_X2X2, MOP_SS: p2 <= mul_res;
        default:          p0 <= mul_res;
      endcase
    end

    // quotient write-back
    if (div_done) begin
      case (cmd.div_op)
        DOP_6:   p1 <= $signed(div_quot);
        DOP_24:  p2 <= $signed(div_quot);
        default: p1 <= $signed(div_quot);
      endcase
    end

    // series seed: s = x - x^3/6, c = 1 - x^2/2 + x^4/24
    if (cmd.seed) begin
      s <= clamp_one($signed(x) - p1, ONE_S);
      c <= clamp_one(ONE_S - (p0 >>> 1) + p2, ONE_S);
    end

    // double-angle step: s = 2sc, c = c^2 - s^2
    if (cmd.update) begin
      s <= clamp_one(p0 <<< 1, ONE_S);
      c <= clamp_one(p1 - p2, ONE_S);
    end

    // output conversion
    if (cmd.finish) begin
      sine_out   <= $signed(to_q28(s_signed));
      cosine_out <= $signed(to_q28(c));
    end
  end

endmodule

`default_nettype wire

[rtl/core/sah_ctrl.sv]
// Controller: sequences halving, seed products and divisions, the
// double-angle steps and the result strobe. Counts halvings.
// Depends on sah_pkg.
`default_nettype none

module sah_ctrl import sah_pkg::*; #(
  parameter int MAX_HALVINGS = MAX_HALVINGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  sah_status_t status,
  output sah_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  localparam int K_W = $clog2(MAX_HALVINGS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HALVE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SEED,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t         state, state_next;
  logic [K_W-1:0] k, k_next;
  mul_op_t        mop, mop_next;
  div_op_t        dop, dop_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    k_next     = k;
    mop_next   = mop;
    dop_next   = dop;
    cmd        = '0;
    cmd.mul_op = mop;
    cmd.div_op = dop;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          k_next     = '0;
          state_next = S_HALVE;
        end
      end
      S_HALVE: begin
        if (status.x_ge_thr && (k < K_W'(MAX_HALVINGS))) begin
          cmd.halve = 1'b1;
          k_next    = k + K_W'(1);
        end else begin
          cmd.clamp_x = 1'b1;
          mop_next    = MOP_XX;
          state_next  = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (status.mul_done) begin
          case (mop)
            MOP_XX: begin
              mop_next   = MOP_X2X;
              state_next = S_MUL_GO;
            end
            MOP_X2X: begin
              mop_next   = MOP_X2X2;
              state_next = S_MUL_GO;
            end
            MOP_X2X2: begin
              dop_next   = DOP_6;
              state_next = S_DIV_GO;
            end
            MOP_SC: begin
              mop_next   = MOP_CC;
              state_next = S_MUL_GO;
            end
            MOP_CC: begin
              mop_next   = MOP_SS;
              state_next = S_MUL_GO;
            end
            MOP_SS: begin
              state_next = S_UPDATE;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          if (dop == DOP_6) begin
            dop_next   = DOP_24;
            state_next = S_DIV_GO;
          end else begin
            state_next = S_SEED;
          end
        end
      end
      S_SEED: begin
        cmd.seed = 1'b1;
        if (k == '0) begin
          state_next = S_FINISH;
        end else begin
          mop_next   = MOP_SC;
          state_next = S_MUL_GO;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        k_next     = k - K_W'(1);
        if (k == K_W'(1)) begin
          state_next = S_FINISH;
        end else begin
          mop_next   = MOP_SC;
          state_next = S_MUL_GO;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      mop   <= MOP_XX;
      dop   <= DOP_6;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      mop   <= mop_next;
      dop   <= dop_next;
      done  <= (state == S_FINISH);
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

[rtl/core/sincos_angle_halving_top.sv]
// Top level of the angle-halving sine/cosine block.
// Joins the controller (sah_ctrl) and the datapath (sah_datapath); uses sah_pkg.
`default_nettype none

// Usage:
//   An item is taken when start is high and busy is low; angle_in is a signed
//   Q3.28 angle in radians. busy stays high while the item is worked on.
//   The result appears on sine_out and cosine_out (signed Q1.28, within
//   plus or minus 1.0) for one cycle, marked by done. The receiver cannot
//   stall; done drops after that cycle.
//   The stop threshold is written through cfg_wr_en / cfg_wr_data while the
//   block is idle; write it between items only.
// Timing:
//   An item is halved k times (k <= MAX_HALVINGS) and gets k double-angle
//   steps. Every product runs through one shared multiplier that forms a
//   32x32 partial product per cycle (three products per double-angle step);
//   the two seed divisions are each a shift, then a divide by 3 as a
//   shift-and-add reciprocal multiply.
//   One item is in flight at a time; a new one may start in the done cycle.
// Reset:
//   rst (synchronous) returns the block to idle and the threshold to 10995.
module sincos_angle_halving_top import sah_pkg::*; #(
  parameter int MAX_HALVINGS    = MAX_HALVINGS_DEF,
  parameter int INNER_FRAC_BITS = INNER_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [ANGLE_W-1:0] angle_in,
  output logic                      done,
  output logic signed [OUT_W-1:0]   sine_out,
  output logic signed [OUT_W-1:0]   cosine_out,
  input  logic                      cfg_wr_en,
  input  logic [THR_W-1:0]          cfg_wr_data
);

  sah_cmd_t    cmd;
  sah_status_t status;

  sah_ctrl #(.MAX_HALVINGS(MAX_HALVINGS)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  sah_datapath #(.FRAC_BITS(INNER_FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .angle_in    (angle_in),
    .cmd         (cmd),
    .status      (status),
    .sine_out    (sine_out),
    .cosine_out  (cosine_out)
  );

`ifndef SYNTH
  // result strobe only after the sequence has finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // an accepted item keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make block busy");

  // one strobe per item
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // outputs stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((cosine_out <= 30'sd268435456) && (cosine_out >= -30'sd268435456) &&
              (sine_out <= 30'sd268435456) && (sine_out >= -30'sd268435456)))
    else $error("result out of range");
`endif

endmodule

`default_nettype wire

[bench/tb_sincos_angle_halving_top.sv]
// Self-checking testbench for sincos_angle_halving_top: drives angles, predicts
// sine and cosine with a bit-exact fixed-point model and checks every result.
// Depends on sah_pkg and the RTL under rtl/core only.
`timescale 1ns / 100ps

module tb_sincos_angle_halving_top;
  import sah_pkg::*;

  localparam int FRAC = INNER_FRAC_DEF;
  localparam int MAXH = MAX_HALVINGS_DEF;
  localparam logic [INNER_W-1:0] ONE_Q = 64'd1 << FRAC;
  localparam logic [INNER_W-1:0] TOP_Q = {1'b0, {(INNER_W-1){1'b1}}};
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 1000;
  localparam int ITEMS_PER_SEG = 155;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic [OUT_W-1:0] sine;
    logic [OUT_W-1:0] cosine;
  } sincos_t;

  // Scoreboard: fixed-point predictor plus queue of expected sine/cosine pairs
  class sincos_scoreboard;
    logic [THR_W-1:0] threshold;
    sincos_t expected_sincos[$];
    int unsigned error_count;

    function new();
      threshold = THR_RESET;
      error_count = 0;
    endfunction

    function void flag(string msg);
      error_count++;
      if (error_count <= REPORT_MAX) $display("MISMATCH: %s", msg);
    endfunction

    // (a*b) >> FRAC on magnitudes, truncating, saturated to the top of range
    function logic [INNER_W-1:0] mul_trunc(logic [INNER_W-1:0] a, logic [INNER_W-1:0] b);
      logic [2*INNER_W-1:0] p;
      logic [INNER_W-1:0] r;
      p = {64'd0, a} * {64'd0, b};
      r = p[FRAC+INNER_W-1:FRAC];
      if ((p >> (FRAC + INNER_W)) != 0 || r[INNER_W-1]) r = TOP_Q;
      return r;
    endfunction

    function logic [INNER_W-1:0] magnitude(logic signed [INNER_W-1:0] v);
      return v[INNER_W-1] ? -v : v;
    endfunction

    // signed product, sign applied after the magnitude product
    function logic signed [INNER_W-1:0] mul_signed(logic signed [INNER_W-1:0] a,
                                                    logic signed [INNER_W-1:0] b);
      logic signed [INNER_W-1:0] m;
      m = mul_trunc(magnitude(a), magnitude(b));
      return (a[INNER_W-1] != b[INNER_W-1]) ? -m : m;
    endfunction

    function logic signed [INNER_W-1:0] sat_unit(logic signed [INNER_W-1:0] v);
      if (v > $signed(ONE_Q)) return ONE_Q;
      if (v < -$signed(ONE_Q)) return -$signed(ONE_Q);
      return v;
    endfunction

    // inner format to Q1.28, truncating toward zero
    function logic [OUT_W-1:0] to_q28(logic signed [INNER_W-1:0] v);
      logic [INNER_W-1:0] m;
      logic [INNER_W-1:0] r;
      m = magnitude(v) >> (FRAC - ANGLE_FRAC);
      r = v[INNER_W-1] ? -m : m;
      return r[OUT_W-1:0];
    endfunction

    function sincos_t predict_sincos(logic [ANGLE_W-1:0] angle);
      logic neg;
      logic [ANGLE_W-1:0] amag;
      logic [INNER_W-1:0] x, thr_q, x2, x3, x4;
      logic signed [INNER_W-1:0] s, c, sc, cc, ss;
      int halvings;
      sincos_t r;
      neg = angle[ANGLE_W-1];
      amag = neg ? -angle : angle;
      x = {32'd0, amag} << (FRAC - ANGLE_FRAC);
      thr_q = {32'd0, threshold} << (FRAC - THR_FRAC);
      // halve until under the threshold or out of halvings
      halvings = 0;
      while (halvings < MAXH && x >= thr_q) begin
        x = x >> 1;
        halvings++;
      end
      if (x > ONE_Q) x = ONE_Q;
      // small-angle seed
      x2 = mul_trunc(x, x);
      x3 = mul_trunc(x2, x);
      x4 = mul_trunc(x2, x2);
      s = sat_unit($signed(x) - $signed(x3 / 64'd6));
      c = sat_unit($signed(ONE_Q) - $signed(x2 / 64'd2) + $signed(x4 / 64'd24));
      // one double-angle step per halving
      repeat (halvings) begin
        sc = mul_signed(s, c);
        cc = mul_signed(c, c);
        ss = mul_signed(s, s);
        s = sat_unit(sc * 2);
        c = sat_unit(cc - ss);
      end
      if (neg) s = -s;
      r.sine = to_q28(s);
      r.cosine = to_q28(c);
      return r;
    endfunction

    function void note_angle(logic [ANGLE_W-1:0] angle);
      expected_sincos.push_back(predict_sincos(angle));
    endfunction

    function void check_result(logic [OUT_W-1:0] sine_got, logic [OUT_W-1:0] cosine_got);
      sincos_t want;
      if (expected_sincos.size() == 0) begin
        flag($sformatf("result with no item pending: sine %0d cosine %0d",
                       $signed(sine_got), $signed(cosine_got)));
        return;
      end
      want = expected_sincos.pop_front();
      if (want.sine !== sine_got)
        flag($sformatf("sine expected %0d got %0d", $signed(want.sine), $signed(sine_got)));
      if (want.cosine !== cosine_got)
        flag($sformatf("cosine expected %0d got %0d",
                       $signed(want.cosine), $signed(cosine_got)));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [ANGLE_W-1:0] angle_in = '0;
  logic done;
  logic signed [OUT_W-1:0] sine_out;
  logic signed [OUT_W-1:0] cosine_out;
  logic cfg_wr_en = 1'b0;
  logic [THR_W-1:0] cfg_wr_data = '0;

  sincos_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int idle_pct = 0;

  sincos_angle_halving_top uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .angle_in   (angle_in),
    .done       (done),
    .sine_out   (sine_out),
    .cosine_out (cosine_out),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result check first, then note a newly accepted item
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(sine_out, cosine_out);
      if (start && !busy) sb.note_angle(angle_in);
    end
  end

  // Offer one item; returns at the edge that accepts it
  task automatic send_angle(input logic [ANGLE_W-1:0] angle);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while (busy);
      repeat ($urandom_range(0, 3)) @(posedge clk);
    end
    start <= 1'b1;
    angle_in <= angle;
    do @(posedge clk); while (busy);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_sincos.size() != 0 || busy);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    sb.threshold = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [ANGLE_W-1:0] random_angle();
    logic [ANGLE_W-1:0] a;
    case ($urandom_range(0, 3))
      0: a = $urandom;
      1: a = $urandom_range(0, 32'h6487ED51);   // up to 2*pi
      2: a = $urandom_range(0, 4095);           // near the threshold
      default: a = 32'd1 << $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1)) a = -a;
    return a;
  endfunction

  logic [ANGLE_W-1:0] directed_angles[] = '{
    32'h00000000, 32'h00000001, 32'h00000002, 32'h00000003,
    32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFD,
    32'h7FFFFFFF, 32'h80000000, 32'h80000001,
    32'h10000000, 32'hF0000000, 32'h1921FB54, 32'h3243F6A9,
    32'hCDBC0957, 32'h6487ED51, 32'h30000000, 32'h55555555, 32'hAAAAAAAA
  };
  logic [ANGLE_W-1:0] zero_thr_angles[] = '{
    32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'h10000000
  };

  // Stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes and known angles at the reset threshold
    idle_pct = 29;
    foreach (directed_angles[i]) send_angle(directed_angles[i]);

    // zero threshold: every item runs the full halving count
    wait_idle();
    write_threshold('0);
    foreach (zero_thr_angles[i]) send_angle(zero_thr_angles[i]);

    // random segments, each with its own threshold
    for (int seg = 0; seg < 6; seg++) begin
      idle_pct = (seg < 2) ? 29 : (seg < 4) ? 77 : 0;
      wait_idle();
      case (seg)
        0: write_threshold(THR_RESET);
        1: write_threshold(32'hFFFFFFFF);
        2: write_threshold(32'd1);
        3: write_threshold($urandom);
        4: write_threshold($urandom_range(1, 32'h00100000));
        default: write_threshold($urandom_range(1, 32'hFFFFFFFF));
      endcase
      repeat (ITEMS_PER_SEG) send_angle(random_angle());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
